[hw/rtl/pfe_pkg.sv]
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_UNDER = 2'd1;
	localparam logic [1:0] STS_DIV0  = 2'd2;
	localparam logic [1:0] STS_OVER  = 2'd3;

	localparam int QDEPTH = 2;
	localparam int QAW    = 1;
	localparam int QCW    = 2;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_PUSH,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] sym;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

endpackage

[hw/rtl/pfe_ram.sv]
// ----------------------------------------------------------------------------
// pfe_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pfe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/pfe_front.sv]
// ----------------------------------------------------------------------------
// pfe_front
// Accepts characters, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module pfe_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [7:0]    symbol,
	input  logic          end_of_expr,
	output logic          full,
	output logic          cmd_valid,
	input  logic          cmd_pop,
	output pfe_pkg::cmd_t cmd
);

	pfe_pkg::cmd_t                ent_q [pfe_pkg::QDEPTH];
	pfe_pkg::cmd_t                cmd_in;
	logic [pfe_pkg::QAW-1:0]      wr_ptr_q;
	logic [pfe_pkg::QAW-1:0]      rd_ptr_q;
	logic [pfe_pkg::QCW-1:0]      cnt_q;
	logic                         wr_en;
	logic                         rd_en;

	always_comb begin
		cmd_in.sym  = symbol;
		cmd_in.last = end_of_expr;
		unique case (symbol)
			pfe_pkg::CH_SPACE: cmd_in.op = pfe_pkg::OP_NOP;
			pfe_pkg::CH_PLUS:  cmd_in.op = pfe_pkg::OP_ADD;
			pfe_pkg::CH_MINUS: cmd_in.op = pfe_pkg::OP_SUB;
			pfe_pkg::CH_STAR:  cmd_in.op = pfe_pkg::OP_MUL;
			pfe_pkg::CH_SLASH: cmd_in.op = pfe_pkg::OP_DIV;
			default:           cmd_in.op = pfe_pkg::OP_PUSH;
		endcase
	end

	assign full      = (cnt_q == pfe_pkg::QCW'(pfe_pkg::QDEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign wr_en     = push && !full;
	assign rd_en     = cmd_pop && cmd_valid;
	assign cmd       = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

[hw/rtl/pfe_div.sv]
// ----------------------------------------------------------------------------
// pfe_div
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module pfe_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pfe_pkg::div_req_t req,
	output pfe_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  step_q;
	logic [31:0] acc_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic [32:0] shifted;
	logic [32:0] trial;
	logic [31:0] acc_n;
	logic        bit_n;
	logic [31:0] mag_a;
	logic [31:0] mag_b;

	assign mag_a = req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
	assign mag_b = req.divisor[31]  ? (32'd0 - req.divisor)  : req.divisor;

	always_comb begin
		shifted = {acc_q, quo_q[31]};
		trial   = shifted - {1'b0, den_q};
		if (!trial[32]) begin
			acc_n = trial[31:0];
			bit_n = 1'b1;
		end else begin
			acc_n = shifted[31:0];
			bit_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 5'd31;
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			quo_q <= mag_a;
			den_q <= mag_b;
			neg_q <= req.dividend[31] ^ req.divisor[31];
		end else if (busy_q) begin
			acc_q <= acc_n;
			quo_q <= {quo_q[30:0], bit_n};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

[hw/rtl/pfe_back.sv]
// ----------------------------------------------------------------------------
// pfe_back
// Executes queued commands on the operand stack and holds the result slot.
// ----------------------------------------------------------------------------
module pfe_back #(
	parameter int STACK_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_pop,
	input  pfe_pkg::cmd_t      cmd,
	output logic signed [31:0] value,
	output logic [1:0]         status,
	output logic               empty,
	input  logic               pop
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_FIN
	} state_t;

	state_t             state_q;
	pfe_pkg::op_t       op_q;
	logic               last_q;
	logic [31:0]        tos_q;
	logic [CW-1:0]      cnt_q;
	logic [1:0]         err_q;
	logic               res_valid_q;
	logic signed [31:0] res_value_q;
	logic [1:0]         res_status_q;

	logic [CW-1:0]      cnt_m1;
	logic [CW-1:0]      cnt_m2;
	logic [31:0]        push_val;
	logic               ram_we;
	logic               ram_re;
	logic [31:0]        lhs;
	logic               slot_free;
	pfe_pkg::div_req_t  div_req;
	pfe_pkg::div_rsp_t  div_rsp;

	assign cnt_m1    = cnt_q - 1'b1;
	assign cnt_m2    = cnt_q - CW'(2);
	assign push_val  = {24'd0, cmd.sym} - {24'd0, pfe_pkg::CH_ZERO};
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign slot_free = !res_valid_q || pop;

	assign ram_we = cmd_pop && (err_q == pfe_pkg::STS_OK) && (cmd.op == pfe_pkg::OP_PUSH)
		&& (cnt_q != CW'(STACK_DEPTH)) && (cnt_q != '0);
	assign ram_re = cmd_pop && (err_q == pfe_pkg::STS_OK)
		&& (cmd.op != pfe_pkg::OP_PUSH) && (cmd.op != pfe_pkg::OP_NOP)
		&& (cnt_q >= CW'(2))
		&& !((cmd.op == pfe_pkg::OP_DIV) && (tos_q == '0));

	pfe_ram #(
		.WIDTH(32),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_m1[AW-1:0]),
		.wdata (tos_q),
		.re    (ram_re),
		.raddr (cnt_m2[AW-1:0]),
		.rdata (lhs)
	);

	assign div_req.start    = (state_q == S_EXEC) && (op_q == pfe_pkg::OP_DIV);
	assign div_req.dividend = lhs;
	assign div_req.divisor  = tos_q;

	pfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= pfe_pkg::OP_NOP;
			last_q       <= 1'b0;
			cnt_q        <= '0;
			err_q        <= pfe_pkg::STS_OK;
			res_valid_q  <= 1'b0;
			res_value_q  <= '0;
			res_status_q <= pfe_pkg::STS_OK;
		end else begin
			if (pop) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q   <= cmd.op;
						last_q <= cmd.last;
						if (cmd.last) begin
							state_q <= S_FIN;
						end
						if (err_q == pfe_pkg::STS_OK) begin
							unique case (cmd.op)
								pfe_pkg::OP_NOP: begin
								end
								pfe_pkg::OP_PUSH: begin
									if (cnt_q == CW'(STACK_DEPTH)) begin
										err_q <= pfe_pkg::STS_OVER;
									end else begin
										cnt_q <= cnt_q + 1'b1;
									end
								end
								default: begin
									if (cnt_q < CW'(2)) begin
										err_q <= pfe_pkg::STS_UNDER;
									end else if ((cmd.op == pfe_pkg::OP_DIV)
										&& (tos_q == '0)) begin
										err_q <= pfe_pkg::STS_DIV0;
									end else begin
										state_q <= S_EXEC;
									end
								end
							endcase
						end
					end
				end
				S_EXEC: begin
					if (op_q == pfe_pkg::OP_DIV) begin
						state_q <= S_DIV;
					end else begin
						cnt_q   <= cnt_m1;
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						cnt_q   <= cnt_m1;
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						if (err_q != pfe_pkg::STS_OK) begin
							res_value_q  <= '0;
							res_status_q <= err_q;
						end else if (cnt_q == '0) begin
							res_value_q  <= '0;
							res_status_q <= pfe_pkg::STS_UNDER;
						end else begin
							res_value_q  <= tos_q;
							res_status_q <= pfe_pkg::STS_OK;
						end
						cnt_q       <= '0;
						err_q       <= pfe_pkg::STS_OK;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && (err_q == pfe_pkg::STS_OK) && (cmd.op == pfe_pkg::OP_PUSH)
			&& (cnt_q != CW'(STACK_DEPTH))) begin
			tos_q <= push_val;
		end else if (state_q == S_EXEC) begin
			unique case (op_q)
				pfe_pkg::OP_ADD: tos_q <= lhs + tos_q;
				pfe_pkg::OP_SUB: tos_q <= lhs - tos_q;
				pfe_pkg::OP_MUL: tos_q <= lhs * tos_q;
				default: begin
				end
			endcase
		end else if ((state_q == S_DIV) && div_rsp.done) begin
			tos_q <= div_rsp.quotient;
		end
	end

	assign value  = res_value_q;
	assign status = res_status_q;
	assign empty  = !res_valid_q;

endmodule

[hw/rtl/postfix_expression_evaluator_core.sv]
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// Evaluates a postfix expression of digits and + - * / one byte at a time.
//
// Input side is a queue: a character is taken when push is high and full low.
// A two-entry command queue sits between the character decoder and the
// stack engine, so characters keep flowing while the engine is busy.
// Result side is a queue: value and status are valid while empty is low and
// are consumed when pop is high; one result per expression, on the byte
// flagged end_of_expr.
// Engine steps: a space or digit is taken in the idle state, + - * add an
// execute state, / adds execute and divide states (32-step shift-subtract
// divider), and the last character adds a finish state to post the result.
// Digits and spaces sustain one character per cycle unless the engine waits
// for a result pop. The top of stack lives in a register, the rest in a
// STACK_DEPTH-entry RAM read through its registered port, hence the
// operators' execute state. Reset empties stack, command queue and result
// slot. If the result is not popped, the engine holds at the next end of
// expression and the command queue fills, after which full stays high.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core #(
	parameter int STACK_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         symbol,
	input  logic               end_of_expr,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] value,
	output logic [1:0]         status
);

	logic          cmd_valid;
	logic          cmd_pop;
	pfe_pkg::cmd_t cmd;

	pfe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.symbol      (symbol),
		.end_of_expr (end_of_expr),
		.full        (full),
		.cmd_valid   (cmd_valid),
		.cmd_pop     (cmd_pop),
		.cmd         (cmd)
	);

	pfe_back #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.value     (value),
		.status    (status),
		.empty     (empty),
		.pop       (pop)
	);

	// engine only consumes commands that exist
	assert property (@(posedge clk) disable iff (!arst_n) cmd_pop |-> cmd_valid)
		else $error("command consumed from empty queue");

	// failed expressions report zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status != pfe_pkg::STS_OK)) |-> (value == 32'sd0))
		else $error("nonzero value with error status");

	// a full input side means commands are pending for the engine
	assert property (@(posedge clk) disable iff (!arst_n) full |-> cmd_valid)
		else $error("input full with no pending command");

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the postfix expression evaluator core. A queue of
// expression characters (directed corner cases, then random well-formed and
// malformed expressions) feeds a clocked driver. Every accepted character
// runs through a behavioral stack evaluator that predicts the value and
// status of each expression. A clocked monitor pops results under random
// backpressure and compares them in order against the predictions.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 16;
	localparam int LONG_HOLD   = 400;
	localparam int RAND_CHARS  = 1200;
	localparam int SETTLE      = 100;

	typedef struct {
		logic [7:0] sym;
		logic       last;
		int         gap;
		bit         drain;
	} char_item_t;

	typedef struct {
		logic signed [31:0] value;
		logic [1:0]         status;
	} eval_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic [7:0]         symbol = 8'd0;
	logic               end_of_expr = 1'b0;
	logic               pop = 1'b0;
	logic               full;
	logic               empty;
	logic signed [31:0] value;
	logic [1:0]         status;

	char_item_t   pending_chars[$];
	eval_result_t expected_results[$];
	logic [7:0]   expr_chars[$];

	// evaluator state mirrored by the bench
	logic [31:0] eval_stack [DEPTH];
	int          eval_depth = 0;
	logic [1:0]  eval_err = pfe_pkg::STS_OK;

	int  exp_total = 0;
	int  results_seen = 0;
	int  mismatches = 0;
	bit  tx_burst = 1'b0;
	bit  drain_next = 1'b0;
	int  tx_wait;
	bit  gap_taken;
	int  rx_wait;
	bit  rx_burst;
	int  hold_left;
	int  hold_count;

	postfix_expression_evaluator_core #(
		.STACK_DEPTH(DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.symbol     (symbol),
		.end_of_expr(end_of_expr),
		.empty      (empty),
		.pop        (pop),
		.value      (value),
		.status     (status)
	);

	always #6 clk = ~clk;

	task automatic eval_char(input logic [7:0] sym, input logic last);
		logic [31:0]  r;
		logic [31:0]  l;
		logic [31:0]  res;
		logic [31:0]  mr;
		logic [31:0]  ml;
		eval_result_t want;
		if (eval_err == pfe_pkg::STS_OK && sym != pfe_pkg::CH_SPACE) begin
			if (sym == pfe_pkg::CH_PLUS || sym == pfe_pkg::CH_MINUS
				|| sym == pfe_pkg::CH_STAR || sym == pfe_pkg::CH_SLASH) begin
				if (eval_depth < 2) begin
					eval_err = pfe_pkg::STS_UNDER;
				end else begin
					r = eval_stack[eval_depth - 1];
					l = eval_stack[eval_depth - 2];
					res = 32'd0;
					case (sym)
						pfe_pkg::CH_PLUS:  res = l + r;
						pfe_pkg::CH_MINUS: res = l - r;
						pfe_pkg::CH_STAR:  res = l * r;
						default: begin
							if (r == 32'd0) begin
								eval_err = pfe_pkg::STS_DIV0;
							end else begin
								// magnitudes, then sign: truncates toward zero and wraps min / -1
								ml = l[31] ? 32'd0 - l : l;
								mr = r[31] ? 32'd0 - r : r;
								res = ml / mr;
								if (l[31] != r[31])
									res = 32'd0 - res;
							end
						end
					endcase
					if (eval_err == pfe_pkg::STS_OK) begin
						eval_depth--;
						eval_stack[eval_depth - 1] = res;
					end
				end
			end else if (eval_depth >= DEPTH) begin
				eval_err = pfe_pkg::STS_OVER;
			end else begin
				eval_stack[eval_depth] = {24'd0, sym} - {24'd0, pfe_pkg::CH_ZERO};
				eval_depth++;
			end
		end
		if (last) begin
			if (eval_err != pfe_pkg::STS_OK) begin
				want.value = 32'sd0;
				want.status = eval_err;
			end else if (eval_depth == 0) begin
				want.value = 32'sd0;
				want.status = pfe_pkg::STS_UNDER;
			end else begin
				want.value = eval_stack[eval_depth - 1];
				want.status = pfe_pkg::STS_OK;
			end
			expected_results.push_back(want);
			eval_depth = 0;
			eval_err = pfe_pkg::STS_OK;
		end
	endtask

	task automatic log_mismatch(input string what, input eval_result_t want);
		if (mismatches < 10)
			$display("%0t: %s: expected value %0d status %0d, got value %0d status %0d",
				$time, what, want.value, want.status, value, status);
		mismatches++;
	endtask

	function automatic logic [7:0] rand_operand();
		logic [7:0] b;
		if ($urandom_range(0, 7) != 0)
			return pfe_pkg::CH_ZERO + 8'($urandom_range(0, 9));
		b = 8'($urandom_range(0, 255));
		while (b == pfe_pkg::CH_PLUS || b == pfe_pkg::CH_MINUS || b == pfe_pkg::CH_STAR
			|| b == pfe_pkg::CH_SLASH || b == pfe_pkg::CH_SPACE)
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	function automatic logic [7:0] rand_operator();
		case ($urandom_range(0, 3))
			0: return pfe_pkg::CH_PLUS;
			1: return pfe_pkg::CH_MINUS;
			2: return pfe_pkg::CH_STAR;
			default: return pfe_pkg::CH_SLASH;
		endcase
	endfunction

	task automatic add_char(input logic [7:0] sym, input logic last);
		char_item_t it;
		it.sym = sym;
		it.last = last;
		it.gap = tx_burst ? 0 : $urandom_range(0, 12);
		it.drain = drain_next;
		drain_next = 1'b0;
		pending_chars.push_back(it);
	endtask

	task automatic emit_expr();
		foreach (expr_chars[i])
			add_char(expr_chars[i], i == expr_chars.size() - 1);
		expr_chars.delete();
	endtask

	// builds min int as 128^4 * 8, then divides it by 0 - 1
	task automatic add_min_div_neg_one();
		expr_chars.push_back(8'hB0);
		expr_chars.push_back(8'hB0);
		expr_chars.push_back(pfe_pkg::CH_STAR);
		expr_chars.push_back(8'hB0);
		expr_chars.push_back(pfe_pkg::CH_STAR);
		expr_chars.push_back(8'hB0);
		expr_chars.push_back(pfe_pkg::CH_STAR);
		expr_chars.push_back(pfe_pkg::CH_ZERO + 8'd8);
		expr_chars.push_back(pfe_pkg::CH_STAR);
		expr_chars.push_back(pfe_pkg::CH_ZERO);
		expr_chars.push_back(pfe_pkg::CH_ZERO + 8'd1);
		expr_chars.push_back(pfe_pkg::CH_MINUS);
		expr_chars.push_back(pfe_pkg::CH_SLASH);
		emit_expr();
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		char_item_t it;
		logic       nxt_push;
		if (!arst_n) begin
			push <= 1'b0;
			symbol <= 8'd0;
			end_of_expr <= 1'b0;
			tx_wait <= 0;
			gap_taken <= 1'b0;
		end else begin
			if (push && !full) begin
				eval_char(symbol, end_of_expr);
				if (end_of_expr)
					exp_total <= exp_total + 1;
			end
			nxt_push = push && full;
			if (!nxt_push) begin
				if (tx_wait != 0) begin
					tx_wait <= tx_wait - 1;
				end else if (pending_chars.size() != 0 &&
						!(pending_chars[0].drain && expected_results.size() != 0)) begin
					if (!gap_taken && pending_chars[0].gap != 0) begin
						tx_wait <= pending_chars[0].gap - 1;
						gap_taken <= 1'b1;
					end else begin
						it = pending_chars.pop_front();
						symbol <= it.sym;
						end_of_expr <= it.last;
						gap_taken <= 1'b0;
						nxt_push = 1'b1;
					end
				end
			end
			push <= nxt_push;
		end
	end

	// long receiver hold-off to fill the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_count <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if ((hold_count == 0 && results_seen == 25) ||
				(hold_count == 1 && results_seen == 120)) begin
			hold_left <= LONG_HOLD;
			hold_count <= hold_count + 1;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		eval_result_t want;
		logic         nxt_pop;
		int           w;
		if (!arst_n) begin
			pop <= 1'b0;
			rx_wait <= 0;
			rx_burst <= 1'b0;
		end else begin
			nxt_pop = pop;
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					want.value = 32'sd0;
					want.status = pfe_pkg::STS_OK;
					log_mismatch("unexpected transaction", want);
				end else begin
					want = expected_results.pop_front();
					if (value !== want.value || status !== want.status)
						log_mismatch("result mismatch", want);
				end
				results_seen <= results_seen + 1;
				if ($urandom_range(0, 39) == 0)
					rx_burst <= !rx_burst;
				w = rx_burst ? 0 : $urandom_range(0, 12);
				if (w == 0 && hold_left == 0) begin
					nxt_pop = 1'b1;
				end else begin
					nxt_pop = 1'b0;
					rx_wait <= w;
				end
			end else if (hold_left != 0) begin
				nxt_pop = 1'b0;
			end else if (!pop) begin
				if (rx_wait != 0)
					rx_wait <= rx_wait - 1;
				else
					nxt_pop = 1'b1;
			end
			pop <= nxt_pop;
		end
	end

	initial begin
		int kind;
		int len;
		int depth;
		int n;
		bit first_rand;

		// negative byte values, all four operators, truncation toward zero,
		// values left below the top
		expr_chars = '{pfe_pkg::CH_ZERO + 8'd5, 8'h00, 8'hFF, pfe_pkg::CH_MINUS,
			pfe_pkg::CH_ZERO + 8'd9, pfe_pkg::CH_STAR, pfe_pkg::CH_ZERO + 8'd7,
			pfe_pkg::CH_SLASH, pfe_pkg::CH_ZERO + 8'd2, pfe_pkg::CH_PLUS};
		emit_expr();
		// operator on an empty stack
		expr_chars = '{pfe_pkg::CH_PLUS};
		emit_expr();
		// divide by zero, then a push that must not count
		expr_chars = '{pfe_pkg::CH_ZERO + 8'd5, pfe_pkg::CH_ZERO, pfe_pkg::CH_SLASH,
			pfe_pkg::CH_ZERO + 8'd1};
		emit_expr();
		// nothing on the stack at the end
		expr_chars = '{pfe_pkg::CH_SPACE};
		emit_expr();
		// final character a space
		expr_chars = '{pfe_pkg::CH_ZERO + 8'd4, pfe_pkg::CH_SPACE};
		emit_expr();
		add_min_div_neg_one();
		// overflow on the push past full depth, then an operator ignored
		for (int i = 0; i <= DEPTH; i++)
			expr_chars.push_back(rand_operand());
		expr_chars.push_back(pfe_pkg::CH_PLUS);
		emit_expr();

		first_rand = 1'b1;
		n = pending_chars.size() + RAND_CHARS;
		while (pending_chars.size() < n) begin
			if ($urandom_range(0, 19) == 0)
				tx_burst = !tx_burst;
			if (first_rand || $urandom_range(0, 24) == 0)
				drain_next = 1'b1;
			first_rand = 1'b0;
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				len = $urandom_range(1, 12);
				depth = 0;
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 7) == 0)
						expr_chars.push_back(pfe_pkg::CH_SPACE);
					if (depth >= 2 && $urandom_range(0, 1) == 1) begin
						expr_chars.push_back(rand_operator());
						depth--;
					end else if (depth < DEPTH) begin
						expr_chars.push_back(rand_operand());
						depth++;
					end
				end
				if ($urandom_range(0, 3) != 0) begin
					while (depth > 1) begin
						expr_chars.push_back(rand_operator());
						depth--;
					end
				end
				if ($urandom_range(0, 9) == 0)
					expr_chars.push_back(pfe_pkg::CH_SPACE);
				emit_expr();
			end else if (kind < 72) begin
				depth = $urandom_range(DEPTH - 3, DEPTH + 2);
				for (int i = 0; i < depth; i++)
					expr_chars.push_back(rand_operand());
				len = $urandom_range(0, depth);
				for (int i = 0; i < len; i++)
					expr_chars.push_back(rand_operator());
				emit_expr();
			end else if (kind < 85) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					expr_chars.push_back(8'($urandom_range(0, 255)));
				emit_expr();
			end else if (kind < 95) begin
				len = $urandom_range(1, 5);
				for (int i = 0; i < len; i++) begin
					case ($urandom_range(0, 2))
						0: expr_chars.push_back(rand_operator());
						1: expr_chars.push_back(rand_operand());
						default: expr_chars.push_back(pfe_pkg::CH_SPACE);
					endcase
				end
				emit_expr();
			end else begin
				if ($urandom_range(0, 1) == 1)
					expr_chars.push_back(rand_operand());
				add_min_div_neg_one();
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_chars.size() != 0 || push)
			@(posedge clk);
		while (exp_total != results_seen)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
